### hw/rtl/stall_bounce_travel_calibrator_unit_macros.svh
// Assertion macros shared by the calibrator RTL; clocked on clock, disabled in reset.
`ifndef STALL_BOUNCE_TRAVEL_CALIBRATOR_UNIT_MACROS_SVH
`define STALL_BOUNCE_TRAVEL_CALIBRATOR_UNIT_MACROS_SVH

// Check a condition in the same cycle as its trigger.
`define SBTC_ASSERT_SAME(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("sbtc check failed");

// Check a condition in the cycle after its trigger.
`define SBTC_ASSERT_NEXT(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("sbtc check failed");

`endif

### hw/rtl/sbtc_pkg.sv
// Shared types and constants of the stall bounce travel calibrator.
`timescale 1ns / 1ps

package sbtc_pkg;

   localparam int COUNT_BITS_DEFAULT = 24;

   localparam int ACTION_W   = 3;
   localparam int READING_W  = 10;
   localparam int PERIOD_W   = 16;
   localparam int STALLS_W   = 4;
   localparam int STEPS_W    = 23;
   localparam int DIFF_W     = 24;
   localparam int SCALE_W    = 16;
   localparam int TOL_W      = 16;
   localparam int EDGES_W    = 16;
   localparam int PSTEP_W    = 8;
   localparam int PHASE_W    = 2;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 16;

   localparam logic [STEPS_W-1:0]  STEPS_MAX = '1;
   localparam logic [DIFF_W-1:0]   DIFF_MAX  = '1;
   localparam logic [STALLS_W-1:0] STALLS_MAX = '1;

   // register reset values
   localparam logic [READING_W-1:0] RST_STALL_THRESHOLD = 10'd1;
   localparam logic [EDGES_W-1:0]   RST_MIN_EDGES       = 16'd140;
   localparam logic [SCALE_W-1:0]   RST_STEP_SCALE      = 16'd160;
   localparam logic [TOL_W-1:0]     RST_MATCH_TOL       = 16'd50;
   localparam logic [STALLS_W-1:0]  RST_MAX_ATTEMPTS    = 4'd6;
   localparam logic [PERIOD_W-1:0]  RST_PERIOD_MIN      = 16'd1;
   localparam logic [PERIOD_W-1:0]  RST_PERIOD_MAX      = 16'd50000;
   localparam logic [PSTEP_W-1:0]   RST_PERIOD_STEP     = 8'd1;
   localparam logic [PERIOD_W-1:0]  RST_TIMER_PERIOD    = 16'd44;

   typedef enum logic [ACTION_W-1:0] {
      ACT_EDGE   = 3'd0,
      ACT_SAMPLE = 3'd1,
      ACT_STOP   = 3'd2,
      ACT_START  = 3'd3,
      ACT_FASTER = 3'd4,
      ACT_SLOWER = 3'd5
   } action_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      REG_STALL_THRESHOLD = 3'd0,
      REG_MIN_EDGES       = 3'd1,
      REG_STEP_SCALE      = 3'd2,
      REG_MATCH_TOL       = 3'd3,
      REG_MAX_ATTEMPTS    = 3'd4,
      REG_PERIOD_MIN      = 3'd5,
      REG_PERIOD_MAX      = 3'd6,
      REG_PERIOD_STEP     = 3'd7
   } reg_index_type;

   typedef enum logic [PHASE_W-1:0] {
      FIN_NONE = 2'd0,
      FIN_DONE = 2'd2,
      FIN_FAIL = 2'd3
   } finish_type;

   typedef enum logic [PHASE_W-1:0] {
      PHASE_MOVING  = 2'd0,
      PHASE_STOPPED = 2'd1,
      PHASE_DONE    = 2'd2,
      PHASE_FAILED  = 2'd3
   } phase_type;

   typedef struct packed {
      logic                timer_running;
      logic                drive_enabled;
      logic                direction;
      logic [PERIOD_W-1:0] step_period;
      phase_type           phase;
      logic [STALLS_W-1:0] stall_count;
      logic [STEPS_W-1:0]  steps_even_run;
      logic [STEPS_W-1:0]  steps_odd_run;
      logic [DIFF_W-1:0]   distance_difference;
   } rsp_beat_type;

endpackage

### hw/rtl/sbtc_if.sv
// Valid/ready channel interfaces of the calibrator: command, result and register write.
`timescale 1ns / 1ps

interface sbtc_req_if
   import sbtc_pkg::*;
();
   logic                 valid;
   logic                 ready;
   logic [ACTION_W-1:0]  action;
   logic [READING_W-1:0] stall_reading;
   logic                 period_elapsed;

   modport source (output valid, action, stall_reading, period_elapsed, input ready);
   modport sink   (input valid, action, stall_reading, period_elapsed, output ready);
endinterface

interface sbtc_rsp_if
   import sbtc_pkg::*;
();
   logic                valid;
   logic                ready;
   logic                timer_running;
   logic                drive_enabled;
   logic                direction;
   logic [PERIOD_W-1:0] step_period;
   logic [PHASE_W-1:0]  phase;
   logic [STALLS_W-1:0] stall_count;
   logic [STEPS_W-1:0]  steps_even_run;
   logic [STEPS_W-1:0]  steps_odd_run;
   logic [DIFF_W-1:0]   distance_difference;

   modport source (output valid, timer_running, drive_enabled, direction, step_period,
                   phase, stall_count, steps_even_run, steps_odd_run,
                   distance_difference, input ready);
   modport sink   (input valid, timer_running, drive_enabled, direction, step_period,
                   phase, stall_count, steps_even_run, steps_odd_run,
                   distance_difference, output ready);
endinterface

interface sbtc_csr_if
   import sbtc_pkg::*;
();
   logic                  valid;
   logic                  ready;
   logic [CSR_IDX_W-1:0]  index;
   logic [CSR_DATA_W-1:0] data;

   modport source (output valid, index, data, input ready);
   modport sink   (input valid, index, data, output ready);
endinterface

### hw/rtl/stall_bounce_travel_calibrator_unit.sv
// Top level of the stall bounce travel calibrator.
`timescale 1ns / 1ps
//
// Usage
//   req_bus : one command beat per event (step edge, status sample, stop, start,
//             faster, slower). Step edges may come every clock while ready.
//   rsp_bus : exactly one status beat per command beat, in command order,
//             reporting timer, enable, direction, period, phase, stall count,
//             the even/odd run step counts and their distance difference.
//   csr_bus : register writes (index, data), always ready. Write only while
//             the block is idle, i.e. every command beat has had its response.
// Command handling and throughput
//   A command is folded into the state in the cycle it is accepted; its
//   response is registered in the output buffer. One command per cycle is
//   sustained while rsp_bus is ready. Stall evaluation (two 23x16 distance
//   products, difference, match compare) is the longest path in that cycle.
// Stalls and reset
//   A two-beat output buffer keeps req_bus ready while one response waits;
//   ready drops only when both beats are held. Synchronous reset restores
//   all but the buffer payload to their defaults and empties the buffer.
//
`include "stall_bounce_travel_calibrator_unit_macros.svh"

module stall_bounce_travel_calibrator_unit
   import sbtc_pkg::*;
#(
   parameter int COUNT_BITS = COUNT_BITS_DEFAULT
) (
   input  logic         clock,
   input  logic         reset,
   sbtc_req_if.sink     req_bus,
   sbtc_rsp_if.source   rsp_bus,
   sbtc_csr_if.sink     csr_bus
);

   // working width for edge count comparisons; always covers the step range
   localparam int WIDE_W = (COUNT_BITS > DIFF_W) ? COUNT_BITS : DIFF_W;
   localparam int PROD_W = STEPS_W + SCALE_W;
   localparam int DIST_W = PROD_W - 8;

   // configuration registers
   logic [READING_W-1:0] stall_threshold_ff;
   logic [EDGES_W-1:0]   min_edges_ff;
   logic [SCALE_W-1:0]   step_scale_ff;
   logic [TOL_W-1:0]     match_tol_ff;
   logic [STALLS_W-1:0]  max_attempts_ff;
   logic [PERIOD_W-1:0]  period_min_ff;
   logic [PERIOD_W-1:0]  period_max_ff;
   logic [PSTEP_W-1:0]   period_step_ff;

   // calibration state
   logic [COUNT_BITS-1:0] edge_count_ff,   edge_count_in;
   logic                  timer_on_ff,     timer_on_in;
   logic                  moving_ff,       moving_in;
   logic                  stall_latched_ff, stall_latched_in;
   logic                  enable_on_ff,    enable_on_in;
   logic                  dir_level_ff,    dir_level_in;
   logic [PERIOD_W-1:0]   timer_period_ff, timer_period_in;
   logic [STALLS_W-1:0]   stalls_seen_ff,  stalls_seen_in;
   logic [STEPS_W-1:0]    even_steps_ff,   even_steps_in;
   logic [STEPS_W-1:0]    odd_steps_ff,    odd_steps_in;
   logic [DIFF_W-1:0]     last_diff_ff,    last_diff_in;
   finish_type            finished_ff,     finished_in;

   // output buffer
   logic [1:0]   fill_ff, fill_in;
   rsp_beat_type head_ff, head_in;
   rsp_beat_type skid_ff, skid_in;
   rsp_beat_type beat_new;

   logic req_take;
   logic rsp_take;

   // evaluation datapath
   logic [WIDE_W-1:0]   edge_wide;
   logic [WIDE_W-1:0]   half_wide;
   logic [STEPS_W-1:0]  half_steps;
   logic [STALLS_W-1:0] stalls_inc;
   logic [STEPS_W-1:0]  eval_even;
   logic [STEPS_W-1:0]  eval_odd;
   logic [PROD_W-1:0]   prod_even;
   logic [PROD_W-1:0]   prod_odd;
   logic [DIST_W-1:0]   dist_even;
   logic [DIST_W-1:0]   dist_odd;
   logic [DIST_W-1:0]   dist_diff;
   logic                runs_match;
   logic                may_retry;

   // sample and speed helpers
   logic                latch_now;
   logic                latched_after;
   logic                do_eval;
   logic [PERIOD_W-1:0] floor_p;
   logic [PERIOD_W:0]   floor_plus;
   logic [PERIOD_W:0]   slow_sum;

   assign req_take = req_bus.valid && req_bus.ready;
   assign rsp_take = rsp_bus.valid && rsp_bus.ready;

   assign csr_bus.ready = 1'b1;

   // ---------------------------------------------------------------------
   // Evaluation of a finished run: halve edges into steps, store them by
   // the parity of the new stall count and compare the truncated distances.
   // ---------------------------------------------------------------------
   assign edge_wide  = WIDE_W'(edge_count_ff);
   assign half_wide  = edge_wide >> 1;
   assign half_steps = (half_wide > WIDE_W'(STEPS_MAX)) ? STEPS_MAX
                                                        : half_wide[STEPS_W-1:0];
   assign stalls_inc = (stalls_seen_ff == STALLS_MAX) ? stalls_seen_ff
                                                      : stalls_seen_ff + 1'b1;
   assign eval_even  = stalls_inc[0] ? even_steps_ff : half_steps;
   assign eval_odd   = stalls_inc[0] ? half_steps : odd_steps_ff;

   assign prod_even = PROD_W'(eval_even) * PROD_W'(step_scale_ff);
   assign prod_odd  = PROD_W'(eval_odd)  * PROD_W'(step_scale_ff);
   assign dist_even = prod_even[PROD_W-1:8];
   assign dist_odd  = prod_odd[PROD_W-1:8];
   assign dist_diff = (dist_even >= dist_odd) ? dist_even - dist_odd
                                              : dist_odd - dist_even;

   assign runs_match = (dist_diff <= DIST_W'(match_tol_ff)) &&
                       (stalls_inc >= STALLS_W'(2));
   assign may_retry  = (stalls_inc <= max_attempts_ff);

   // stall latch on a status sample; the same sample may also evaluate
   assign latch_now = !stall_latched_ff &&
                      (req_bus.stall_reading <= stall_threshold_ff) &&
                      (edge_wide >= WIDE_W'(min_edges_ff));
   assign latched_after = stall_latched_ff || latch_now;
   assign do_eval = req_bus.period_elapsed && latched_after && moving_ff;

   // period bounds
   assign floor_p    = (period_min_ff == '0) ? PERIOD_W'(1) : period_min_ff;
   assign floor_plus = {1'b0, floor_p} + (PERIOD_W + 1)'(period_step_ff);
   assign slow_sum   = {1'b0, timer_period_ff} + (PERIOD_W + 1)'(period_step_ff);

   // ---------------------------------------------------------------------
   // Next state for the accepted command
   // ---------------------------------------------------------------------
   always_comb begin
      edge_count_in    = edge_count_ff;
      timer_on_in      = timer_on_ff;
      moving_in        = moving_ff;
      stall_latched_in = stall_latched_ff;
      enable_on_in     = enable_on_ff;
      dir_level_in     = dir_level_ff;
      timer_period_in  = timer_period_ff;
      stalls_seen_in   = stalls_seen_ff;
      even_steps_in    = even_steps_ff;
      odd_steps_in     = odd_steps_ff;
      last_diff_in     = last_diff_ff;
      finished_in      = finished_ff;

      // once calibrated, hold everything
      if (req_take && finished_ff != FIN_DONE) begin
         case (action_type'(req_bus.action))
            ACT_EDGE: begin
               if (timer_on_ff && edge_count_ff != '1) begin
                  edge_count_in = edge_count_ff + 1'b1;
               end
            end
            ACT_SAMPLE: begin
               if (latch_now) begin
                  timer_on_in      = 1'b0;
                  stall_latched_in = 1'b1;
               end
               if (do_eval) begin
                  moving_in      = 1'b0;
                  dir_level_in   = !dir_level_ff;
                  stalls_seen_in = stalls_inc;
                  edge_count_in  = COUNT_BITS'(half_wide);
                  even_steps_in  = eval_even;
                  odd_steps_in   = eval_odd;
                  last_diff_in   = (dist_diff > DIST_W'(DIFF_MAX)) ? DIFF_MAX
                                                                   : dist_diff[DIFF_W-1:0];
                  if (runs_match) begin
                     finished_in = FIN_DONE;
                  end else if (may_retry) begin
                     edge_count_in    = '0;
                     timer_on_in      = 1'b1;
                     stall_latched_in = 1'b0;
                     moving_in        = 1'b1;
                     enable_on_in     = 1'b1;
                  end else begin
                     enable_on_in = 1'b0;
                     finished_in  = FIN_FAIL;
                  end
               end
            end
            ACT_STOP: begin
               if (enable_on_ff) begin
                  timer_on_in  = 1'b0;
                  moving_in    = 1'b0;
                  enable_on_in = 1'b0;
               end
            end
            ACT_START: begin
               edge_count_in    = '0;
               timer_on_in      = 1'b1;
               stall_latched_in = 1'b0;
               moving_in        = 1'b1;
               enable_on_in     = 1'b1;
               finished_in      = FIN_NONE;
            end
            ACT_FASTER: begin
               if (timer_period_ff > floor_p) begin
                  timer_period_in = ({1'b0, timer_period_ff} >= floor_plus)
                                  ? timer_period_ff - PERIOD_W'(period_step_ff)
                                  : floor_p;
               end
            end
            ACT_SLOWER: begin
               if (timer_period_ff < period_max_ff) begin
                  timer_period_in = (slow_sum > {1'b0, period_max_ff})
                                  ? period_max_ff : slow_sum[PERIOD_W-1:0];
               end
            end
            default: begin
            end
         endcase
      end
   end

   // response beat built from the state after this command
   always_comb begin
      beat_new.timer_running       = timer_on_in;
      beat_new.drive_enabled       = enable_on_in;
      beat_new.direction           = dir_level_in;
      beat_new.step_period         = timer_period_in;
      beat_new.stall_count         = stalls_seen_in;
      beat_new.steps_even_run      = even_steps_in;
      beat_new.steps_odd_run       = odd_steps_in;
      beat_new.distance_difference = last_diff_in;
      if (finished_in == FIN_DONE) begin
         beat_new.phase = PHASE_DONE;
      end else if (finished_in == FIN_FAIL) begin
         beat_new.phase = PHASE_FAILED;
      end else if (timer_on_in) begin
         beat_new.phase = PHASE_MOVING;
      end else begin
         beat_new.phase = PHASE_STOPPED;
      end
   end

   // ---------------------------------------------------------------------
   // Two-beat output buffer: head drives rsp_bus, skid catches a beat
   // that arrives while head is stalled.
   // ---------------------------------------------------------------------
   always_comb begin
      fill_in = fill_ff;
      head_in = head_ff;
      skid_in = skid_ff;
      if (fill_ff == 2'd0) begin
         if (req_take) begin
            head_in = beat_new;
            fill_in = 2'd1;
         end
      end else if (fill_ff == 2'd1) begin
         if (req_take && rsp_take) begin
            head_in = beat_new;
         end else if (req_take) begin
            skid_in = beat_new;
            fill_in = 2'd2;
         end else if (rsp_take) begin
            fill_in = 2'd0;
         end
      end else begin
         if (rsp_take) begin
            head_in = skid_ff;
            fill_in = 2'd1;
         end
      end
   end

   assign req_bus.ready = (fill_ff != 2'd2);
   assign rsp_bus.valid = (fill_ff != 2'd0);

   assign rsp_bus.timer_running       = head_ff.timer_running;
   assign rsp_bus.drive_enabled       = head_ff.drive_enabled;
   assign rsp_bus.direction           = head_ff.direction;
   assign rsp_bus.step_period         = head_ff.step_period;
   assign rsp_bus.phase               = head_ff.phase;
   assign rsp_bus.stall_count         = head_ff.stall_count;
   assign rsp_bus.steps_even_run      = head_ff.steps_even_run;
   assign rsp_bus.steps_odd_run       = head_ff.steps_odd_run;
   assign rsp_bus.distance_difference = head_ff.distance_difference;

   // ---------------------------------------------------------------------
   // Registers
   // ---------------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (reset) begin
         stall_threshold_ff <= RST_STALL_THRESHOLD;
         min_edges_ff       <= RST_MIN_EDGES;
         step_scale_ff      <= RST_STEP_SCALE;
         match_tol_ff       <= RST_MATCH_TOL;
         max_attempts_ff    <= RST_MAX_ATTEMPTS;
         period_min_ff      <= RST_PERIOD_MIN;
         period_max_ff      <= RST_PERIOD_MAX;
         period_step_ff     <= RST_PERIOD_STEP;
      end else if (csr_bus.valid && csr_bus.ready) begin
         unique case (reg_index_type'(csr_bus.index))
            REG_STALL_THRESHOLD: stall_threshold_ff <= csr_bus.data[READING_W-1:0];
            REG_MIN_EDGES:       min_edges_ff       <= csr_bus.data[EDGES_W-1:0];
            REG_STEP_SCALE:      step_scale_ff      <= csr_bus.data[SCALE_W-1:0];
            REG_MATCH_TOL:       match_tol_ff       <= csr_bus.data[TOL_W-1:0];
            REG_MAX_ATTEMPTS:    max_attempts_ff    <= csr_bus.data[STALLS_W-1:0];
            REG_PERIOD_MIN:      period_min_ff      <= csr_bus.data[PERIOD_W-1:0];
            REG_PERIOD_MAX:      period_max_ff      <= csr_bus.data[PERIOD_W-1:0];
            REG_PERIOD_STEP:     period_step_ff     <= csr_bus.data[PSTEP_W-1:0];
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         edge_count_ff    <= '0;
         timer_on_ff      <= 1'b1;
         moving_ff        <= 1'b1;
         stall_latched_ff <= 1'b0;
         enable_on_ff     <= 1'b1;
         dir_level_ff     <= 1'b0;
         timer_period_ff  <= RST_TIMER_PERIOD;
         stalls_seen_ff   <= '0;
         even_steps_ff    <= '0;
         odd_steps_ff     <= '0;
         last_diff_ff     <= '0;
         finished_ff      <= FIN_NONE;
         fill_ff          <= 2'd0;
      end else begin
         edge_count_ff    <= edge_count_in;
         timer_on_ff      <= timer_on_in;
         moving_ff        <= moving_in;
         stall_latched_ff <= stall_latched_in;
         enable_on_ff     <= enable_on_in;
         dir_level_ff     <= dir_level_in;
         timer_period_ff  <= timer_period_in;
         stalls_seen_ff   <= stalls_seen_in;
         even_steps_ff    <= even_steps_in;
         odd_steps_ff     <= odd_steps_in;
         last_diff_ff     <= last_diff_in;
         finished_ff      <= finished_in;
         fill_ff          <= fill_in;
      end
   end

   // payload of the output buffer needs no reset
   always_ff @(posedge clock) begin
      head_ff <= head_in;
      skid_ff <= skid_in;
   end

   // ---------------------------------------------------------------------
   // Assertions
   // ---------------------------------------------------------------------
   // calibrated is final until reset
   `SBTC_ASSERT_NEXT(a_done_holds, finished_ff == FIN_DONE, finished_ff == FIN_DONE)
   // the timer never runs with the driver disabled
   `SBTC_ASSERT_SAME(a_timer_needs_enable, timer_on_ff, enable_on_ff)
   // a latched stall always has the timer stopped
   `SBTC_ASSERT_SAME(a_latch_stops_timer, stall_latched_ff, !timer_on_ff)
   // the stall count only ever advances by one
   `SBTC_ASSERT_SAME(a_stalls_step,
      !$past(reset) && stalls_seen_ff != $past(stalls_seen_ff),
      stalls_seen_ff == $past(stalls_seen_ff) + 4'd1)

endmodule
